### hw/rtl/sle_pkg.sv
// ----------------------------------------------------------------------------
// sle_pkg
// Shared types and constants for the serial line editor with echo.
// ----------------------------------------------------------------------------
package sle_pkg;

	localparam int LINE_CAPACITY_DEF = 32;
	localparam int CNT_W             = 6;   // holds any capacity up to 63
	localparam int BYTE_W            = 8;

	localparam logic [BYTE_W-1:0] CH_LF = 8'h0A;
	localparam logic [BYTE_W-1:0] CH_CR = 8'h0D;
	localparam logic [BYTE_W-1:0] CH_BS = 8'h08;

	localparam logic CMD_RX   = 1'b0;
	localparam logic CMD_READ = 1'b1;

	typedef enum logic [1:0] {
		KIND_ECHO = 2'd0,
		KIND_LINE = 2'd1,
		KIND_NONE = 2'd2,
		KIND_END  = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ECHO_LF,
		ST_READ,
		ST_END
	} state_t;

	// store access request from the controller
	typedef struct packed {
		logic              we;
		logic [CNT_W-1:0]  waddr;
		logic [BYTE_W-1:0] wdata;
		logic              re;
		logic [CNT_W-1:0]  raddr;
	} mem_req_t;

endpackage

### hw/rtl/sle_line_mem.sv
// ----------------------------------------------------------------------------
// sle_line_mem
// Line store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sle_line_mem #(
	parameter int LINE_CAPACITY = sle_pkg::LINE_CAPACITY_DEF
) (
	input  logic                      clk,
	input  sle_pkg::mem_req_t         req,
	output logic [sle_pkg::BYTE_W-1:0] rdata
);
	import sle_pkg::*;

	localparam int AW = (LINE_CAPACITY > 1) ? $clog2(LINE_CAPACITY) : 1;

	logic [BYTE_W-1:0] mem_q [LINE_CAPACITY];
	logic [BYTE_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem_q[req.waddr[AW-1:0]] <= req.wdata;
		end
		if (req.re) begin
			rdata_q <= mem_q[req.raddr[AW-1:0]];
		end
	end

	assign rdata = rdata_q;

endmodule

### hw/rtl/sle_ctrl.sv
// ----------------------------------------------------------------------------
// sle_ctrl
// Line editing sequencer: count, ready flag, store access and result register.
// ----------------------------------------------------------------------------
module sle_ctrl #(
	parameter int LINE_CAPACITY = sle_pkg::LINE_CAPACITY_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic                       cmd,
	input  logic [sle_pkg::BYTE_W-1:0] rx_byte,
	output logic                       strobe,
	output logic [1:0]                 out_kind,
	output logic [sle_pkg::BYTE_W-1:0] out_data,
	output logic                       last,
	output sle_pkg::mem_req_t          mem_req,
	input  logic [sle_pkg::BYTE_W-1:0] mem_rdata
);
	import sle_pkg::*;

	localparam logic [CNT_W-1:0] CAP = CNT_W'(LINE_CAPACITY);

	state_t            state_q, state_d;
	logic [CNT_W-1:0]  count_q, count_d;
	logic [CNT_W-1:0]  idx_q, idx_d;
	logic              ready_q, ready_d;
	logic              strobe_q, strobe_d;
	kind_t             kind_q, kind_d;
	logic [BYTE_W-1:0] data_q, data_d;
	logic              last_q, last_d;
	logic              accept;

	assign accept = start && (state_q == ST_IDLE);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (cmd == CMD_READ) begin
						if (ready_q && (count_q != '0)) state_d = ST_READ;
					end else if (!ready_q && (rx_byte == CH_CR)) begin
						state_d = ST_ECHO_LF;
					end
				end
			end
			ST_ECHO_LF: state_d = ST_IDLE;
			ST_READ: begin
				if (CNT_W'(idx_q + 1'b1) == count_q) state_d = ST_END;
			end
			ST_END:  state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// datapath and result loads
	always_comb begin
		count_d     = count_q;
		idx_d       = idx_q;
		ready_d     = ready_q;
		strobe_d    = 1'b0;
		kind_d      = kind_q;
		data_d      = data_q;
		last_d      = last_q;
		mem_req     = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (cmd == CMD_READ) begin
						if (!ready_q) begin
							strobe_d = 1'b1;
							kind_d   = KIND_NONE;
							data_d   = '0;
							last_d   = 1'b1;
						end else if (count_q == '0) begin
							strobe_d = 1'b1;
							kind_d   = KIND_END;
							data_d   = '0;
							last_d   = 1'b1;
							ready_d  = 1'b0;
						end else begin
							mem_req.re    = 1'b1;
							mem_req.raddr = '0;
							idx_d         = '0;
						end
					end else if (!ready_q) begin
						if (rx_byte == CH_CR) begin
							ready_d  = 1'b1;
							strobe_d = 1'b1;
							kind_d   = KIND_ECHO;
							data_d   = CH_CR;
							last_d   = 1'b0;
						end else if (rx_byte == CH_BS) begin
							if (count_q != '0) begin
								count_d  = count_q - 1'b1;
								strobe_d = 1'b1;
								kind_d   = KIND_ECHO;
								data_d   = CH_BS;
								last_d   = 1'b1;
							end
						end else if (rx_byte != CH_LF) begin
							if (count_q < CAP) begin
								mem_req.we    = 1'b1;
								mem_req.waddr = count_q;
								mem_req.wdata = rx_byte;
								count_d       = count_q + 1'b1;
								strobe_d      = 1'b1;
								kind_d        = KIND_ECHO;
								data_d        = rx_byte;
								last_d        = 1'b1;
							end
						end
					end
				end
			end
			ST_ECHO_LF: begin
				strobe_d = 1'b1;
				kind_d   = KIND_ECHO;
				data_d   = CH_LF;
				last_d   = 1'b1;
			end
			ST_READ: begin
				// read data for idx_q is valid now; fetch the next entry
				strobe_d      = 1'b1;
				kind_d        = KIND_LINE;
				data_d        = mem_rdata;
				last_d        = 1'b0;
				idx_d         = idx_q + 1'b1;
				mem_req.re    = 1'b1;
				mem_req.raddr = idx_q + 1'b1;
			end
			ST_END: begin
				strobe_d = 1'b1;
				kind_d   = KIND_END;
				data_d   = '0;
				last_d   = 1'b1;
				count_d  = '0;
				ready_d  = 1'b0;
			end
			default: ;
		endcase
		if ((state_q == ST_IDLE) && accept && (cmd == CMD_READ) && ready_q
				&& (count_q == '0)) begin
			count_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			count_q  <= '0;
			idx_q    <= '0;
			ready_q  <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			count_q  <= count_d;
			idx_q    <= idx_d;
			ready_q  <= ready_d;
			strobe_q <= strobe_d;
		end
	end

	always_ff @(posedge clk) begin
		kind_q <= kind_d;
		data_q <= data_d;
		last_q <= last_d;
	end

	assign busy     = (state_q != ST_IDLE);
	assign strobe   = strobe_q;
	assign out_kind = kind_q;
	assign out_data = data_q;
	assign last     = last_q;

endmodule

### hw/rtl/serial_line_editor_with_echo_unit.sv
// ----------------------------------------------------------------------------
// serial_line_editor_with_echo_unit
// Canonical line editor: stores received bytes, echoes them, hands over lines.
//
//   channel   handshake       payload
//   command   start / busy    cmd, rx_byte
//   result    strobe          out_kind, out_data, last
//
// Echo and no-line results appear the cycle after their beat; echo-only beats
// keep busy low. CR keeps busy high while the LF echo follows the CR echo.
// A read of a line keeps busy high through its bytes and the end marker, one
// store read per byte; its first line byte comes behind the store read and
// the result register. Reset clears the count, ready flag and sequencer, not the store.
// The receiver cannot stall: each result shows for exactly one cycle.
// ----------------------------------------------------------------------------
module serial_line_editor_with_echo_unit #(
	parameter int LINE_CAPACITY = sle_pkg::LINE_CAPACITY_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic                       cmd,
	input  logic [sle_pkg::BYTE_W-1:0] rx_byte,
	output logic                       strobe,
	output logic [1:0]                 out_kind,
	output logic [sle_pkg::BYTE_W-1:0] out_data,
	output logic                       last
);
	import sle_pkg::*;

	mem_req_t          mem_req;
	logic [BYTE_W-1:0] mem_rdata;

	sle_ctrl #(
		.LINE_CAPACITY(LINE_CAPACITY)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.cmd      (cmd),
		.rx_byte  (rx_byte),
		.strobe   (strobe),
		.out_kind (out_kind),
		.out_data (out_data),
		.last     (last),
		.mem_req  (mem_req),
		.mem_rdata(mem_rdata)
	);

	sle_line_mem #(
		.LINE_CAPACITY(LINE_CAPACITY)
	) u_mem (
		.clk  (clk),
		.req  (mem_req),
		.rdata(mem_rdata)
	);

endmodule

### hw/rtl/sle_chk.sv
// ----------------------------------------------------------------------------
// sle_chk
// Port-level checks on the result stream of the line editor.
// ----------------------------------------------------------------------------
module sle_chk (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       start,
	input logic                       busy,
	input logic                       cmd,
	input logic                       strobe,
	input logic [1:0]                 out_kind,
	input logic [sle_pkg::BYTE_W-1:0] out_data,
	input logic                       last
);
	import sle_pkg::*;

	// a read beat always answers with a result or starts a line transfer
	a_read_answers: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (cmd == CMD_READ) |=> strobe || busy)
		else $error("read beat produced neither result nor transfer");

	a_none_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && (out_kind == KIND_NONE) |-> last && (out_data == '0))
		else $error("no-line result malformed");

	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && (out_kind == KIND_END) |-> last && (out_data == '0))
		else $error("end marker malformed");

	a_line_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && (out_kind == KIND_LINE) |-> !last)
		else $error("line byte flagged last");

endmodule

bind serial_line_editor_with_echo_unit sle_chk u_sle_chk (
	.clk     (clk),
	.arst_n  (arst_n),
	.start   (start),
	.busy    (busy),
	.cmd     (cmd),
	.strobe  (strobe),
	.out_kind(out_kind),
	.out_data(out_data),
	.last    (last)
);
